// File: design/uvst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvst_pkg
// Shared types and codes for the unique value set table.
// ----------------------------------------------------------------------------
package uvst_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 6;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_ERASE,
    OP_LOOKUP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               valid;
    logic               was_present;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_MOVE
  } state_t;

endpackage

// File: design/uvst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module uvst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/uvst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvst_front
// Accepts commands, decodes them into operations and queues up to two requests.
// ----------------------------------------------------------------------------
module uvst_front
  import uvst_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         command,
  input  logic [VALUE_W-1:0] value,
  output logic               busy,
  output logic               q_valid,
  output req_t               q_req,
  input  logic               q_pop
);

  req_t       q_mem_r [2];
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       push;
  req_t       req_c;

  always_comb begin
    req_c.value = value;
    case (command)
      CMD_INSERT: req_c.op = OP_INSERT;
      CMD_ERASE:  req_c.op = OP_ERASE;
      CMD_LOOKUP: req_c.op = OP_LOOKUP;
      default:    req_c.op = OP_LOOKUP;  // unused code acts as a lookup
    endcase
  end

  assign busy    = (q_cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_req   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? !rd_ptr_r : rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push && !(q_pop && q_valid)) begin
      q_cnt_nxt = q_cnt_r + 2'd1;
    end else if (!push && q_pop && q_valid) begin
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      q_cnt_r  <= q_cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= req_c;
    end
  end

endmodule

// File: design/uvst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvst_back
// Executes queued requests: linear search of the store, then append,
// move-last-into-hole on erase, and one result per request.
// ----------------------------------------------------------------------------
module uvst_back
  import uvst_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  req_t    q_req,
  output logic    q_pop,
  output result_t res
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t           state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [CNT_W-1:0] fill_count_r, fill_count_nxt;
  logic [CNT_W-1:0] issue_idx_r, issue_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pend_idx_r, pend_idx_nxt;
  logic             found_r, found_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic             res_valid_r, res_valid_nxt;
  logic             res_present_r, res_present_nxt;
  logic [1:0]       res_status_r, res_status_nxt;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [VALUE_W-1:0] mem_wdata, mem_rdata;

  logic               hit, more, full;
  logic [CNT_W-1:0]   last_idx;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  uvst_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign hit      = pend_r && (mem_rdata == req_r.value);
  assign more     = (issue_idx_r < fill_count_r);
  assign full     = (fill_count_r == CNT_W'(CAPACITY));
  assign last_idx = fill_count_r - 1'b1;
  assign cnt_ext  = {{COUNT_W{1'b0}}, fill_count_r};

  assign res.valid       = res_valid_r;
  assign res.was_present = res_present_r;
  assign res.status      = res_status_r;
  assign res.count       = cnt_ext[COUNT_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (hit || (!pend_r && !more)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (req_r.op == OP_ERASE && found_r) state_nxt = S_MOVE;
        else state_nxt = S_IDLE;
      end
      S_MOVE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt         = req_r;
    fill_count_nxt  = fill_count_r;
    issue_idx_nxt   = issue_idx_r;
    pend_nxt        = pend_r;
    pend_idx_nxt    = pend_idx_r;
    found_nxt       = found_r;
    slot_nxt        = slot_r;
    res_valid_nxt   = 1'b0;
    res_present_nxt = res_present_r;
    res_status_nxt  = res_status_r;
    q_pop           = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = fill_count_r[AW-1:0];
    mem_wdata       = req_r.value;
    mem_re          = 1'b0;
    mem_raddr       = issue_idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          req_nxt       = q_req;
          issue_idx_nxt = '0;
          pend_nxt      = 1'b0;
          found_nxt     = 1'b0;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          found_nxt = 1'b1;
          slot_nxt  = pend_idx_r;
          pend_nxt  = 1'b0;
        end else if (more) begin
          // issue next read while the previous one is compared
          mem_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_idx_nxt  = issue_idx_r[AW-1:0];
          issue_idx_nxt = issue_idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_DECIDE: begin
        res_present_nxt = found_r;
        res_status_nxt  = ST_DONE;
        res_valid_nxt   = 1'b1;
        case (req_r.op)
          OP_INSERT: begin
            if (found_r) begin
              res_status_nxt = ST_PRESENT;
            end else if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we         = 1'b1;
              fill_count_nxt = fill_count_r + 1'b1;
            end
          end
          OP_ERASE: begin
            if (found_r) begin
              // fetch the last entry; the result goes out after the move
              mem_re        = 1'b1;
              mem_raddr     = last_idx[AW-1:0];
              res_valid_nxt = 1'b0;
            end else begin
              res_status_nxt = ST_ABSENT;
            end
          end
          default: ;
        endcase
      end
      S_MOVE: begin
        mem_we          = 1'b1;
        mem_waddr       = slot_r;
        mem_wdata       = mem_rdata;
        fill_count_nxt  = last_idx;
        res_valid_nxt   = 1'b1;
        res_present_nxt = 1'b1;
        res_status_nxt  = ST_DONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_count_r <= '0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      pend_r       <= pend_nxt;
      found_r      <= found_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    issue_idx_r   <= issue_idx_nxt;
    pend_idx_r    <= pend_idx_nxt;
    slot_r        <= slot_nxt;
    res_present_r <= res_present_nxt;
    res_status_r  <= res_status_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> $past(state_r == S_DECIDE || state_r == S_MOVE))
    else $error("result strobe outside decide or move");

  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && fill_count_r != $past(fill_count_r)) |-> res_valid_r)
    else $error("fill count changed without a result");

  a_move_after_erase_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> $past(found_r && req_r.op == OP_ERASE))
    else $error("move without an erase hit");

endmodule

// File: design/unique_value_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_set_table
// Set of distinct 32-bit values in a fixed store with a fill count.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_command (0 insert, 1 erase, 2 lookup) and in_value with start
//   high; the request is taken on a clock edge where busy is low. A two-deep
//   request queue sits in front of the executing engine, so busy rises only
//   when two requests wait behind the one in progress.
//   Each request yields one result, shown for exactly one cycle with
//   out_valid high: out_was_present, out_status (0 done, 1 already present,
//   2 not found, 3 full) and out_count, the fill count after the request.
//   The receiver cannot stall; results must be taken as they appear.
//   The search reads one stored entry per cycle from the store RAM, and an
//   erase that hits then reads the last entry and moves it into the freed
//   slot. Requests run one at a time.
//   Reset empties the set (fill count zero); store contents need no clearing.
// ----------------------------------------------------------------------------
module unique_value_set_table
  import uvst_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic               out_was_present,
  output logic [1:0]         out_status,
  output logic [5:0]         out_count
);

  logic    q_valid;
  logic    q_pop;
  req_t    q_req;
  result_t res;

  uvst_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .command(in_command),
    .value  (in_value),
    .busy   (busy),
    .q_valid(q_valid),
    .q_req  (q_req),
    .q_pop  (q_pop)
  );

  uvst_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_req  (q_req),
    .q_pop  (q_pop),
    .res    (res)
  );

  assign out_valid       = res.valid;
  assign out_was_present = res.was_present;
  assign out_status      = res.status;
  assign out_count       = res.count;

endmodule

// File: bench/set_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_table_checker
// Tracks the contents of the value set from the accepted requests, works out
// the reply that each request must produce and compares every reply that the
// table shows, field by field and in order. Failures are counted for the top.
// ----------------------------------------------------------------------------
module set_table_checker
  import uvst_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_command,
  input  logic [31:0]        in_value,
  input  logic               out_valid,
  input  logic               out_was_present,
  input  logic [1:0]         out_status,
  input  logic [5:0]         out_count,
  output int                 pending,
  output int                 fail_count
);

  typedef struct packed {
    logic               was_present;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } set_reply_t;

  logic [VALUE_W-1:0] members [CAPACITY];
  int unsigned        member_count;
  set_reply_t         replies_due [$];
  int unsigned        reply_index;

  initial fail_count = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH reply %0d: %s", $realtime, reply_index, msg);
    fail_count++;
  endtask

  // Apply one request to the tracked set and return the reply it must give.
  function automatic set_reply_t next_set_reply(input logic [1:0] cmd,
                                                input logic [VALUE_W-1:0] val);
    set_reply_t  reply;
    int unsigned slot;
    logic        hit;
    slot = member_count;
    for (int i = 0; i < member_count; i++) begin
      if (slot == member_count && members[i] == val) slot = i;
    end
    hit               = (slot < member_count);
    reply.was_present = hit;
    reply.status      = ST_DONE;
    case (cmd)
      CMD_INSERT: begin
        if (hit) begin
          reply.status = ST_PRESENT;
        end else if (member_count >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          members[member_count] = val;
          member_count++;
        end
      end
      CMD_ERASE: begin
        if (!hit) begin
          reply.status = ST_ABSENT;
        end else begin
          // fill the freed slot with the last entry
          member_count--;
          members[slot] = members[member_count];
        end
      end
      default: ;
    endcase
    reply.count = member_count[COUNT_W-1:0];
    return reply;
  endfunction

  always @(posedge clk) begin
    set_reply_t want;
    if (!rst_n) begin
      member_count = 0;
      reply_index  = 0;
      replies_due.delete();
    end else begin
      if (start && !busy) replies_due.push_back(next_set_reply(in_command, in_value));
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply with no request outstanding");
        end else begin
          want = replies_due.pop_front();
          if (out_was_present !== want.was_present)
            report_mismatch($sformatf("was_present got %0b want %0b",
                                      out_was_present, want.was_present));
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", out_count, want.count));
        end
        reply_index++;
      end
    end
    pending <= replies_due.size();
  end

endmodule

// File: bench/unique_value_set_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_set_table_test
// Drives insert, erase, lookup and reserved-code requests into the set table: a directed
// pass over the boundary values and special cases, then rounds of random
// requests drawn mostly from a shared value pool so the set fills, overflows
// and drains. A checker beside the table predicts and compares every reply.
// ----------------------------------------------------------------------------
module unique_value_set_table_test
  import uvst_pkg::*;
();

  localparam int         CAPACITY     = 32;
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int         POOL_SIZE    = 64;
  localparam int         ROUNDS       = 12;
  localparam int         ROUND_ITEMS  = 100;
  localparam int         SETTLE_CYCLES = 60;
  localparam int         STALL_LIMIT  = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_LOOKUP;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_was_present;
  logic [1:0]  out_status;
  logic [5:0]  out_count;
  int          pending;
  int          fail_count;

  logic [31:0] value_pool [POOL_SIZE];
  bit          idle_on = 1'b1;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  unique_value_set_table #(.CAPACITY(CAPACITY)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_was_present (out_was_present),
    .out_status      (out_status),
    .out_count       (out_count)
  );

  set_table_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_was_present (out_was_present),
    .out_status      (out_status),
    .out_count       (out_count),
    .pending         (pending),
    .fail_count      (fail_count)
  );

  // Hold start high across back-to-back requests; lower it only for a gap.
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] val);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [1:0] pick_command(input int ins_pct);
    int roll;
    int rest;
    roll = $urandom_range(0, 99);
    rest = 97 - ins_pct;
    if (roll < 3) return CMD_RESERVED;
    if (roll < 3 + ins_pct) return CMD_INSERT;
    if (roll < 3 + ins_pct + rest * 2 / 3) return CMD_ERASE;
    return CMD_LOOKUP;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int window;
    int ins_pct;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty set, extremes, duplicates, reserved code, erase moves
    send_request(CMD_LOOKUP,   32'h0000_0000);
    send_request(CMD_ERASE,    32'h0000_0000);
    send_request(CMD_INSERT,   32'h8000_0000);
    send_request(CMD_INSERT,   32'h7FFF_FFFF);
    send_request(CMD_INSERT,   32'h0000_0000);
    send_request(CMD_INSERT,   32'hFFFF_FFFF);
    send_request(CMD_INSERT,   32'h7FFF_FFFF);
    send_request(CMD_LOOKUP,   32'h8000_0000);
    send_request(CMD_LOOKUP,   32'h0000_0001);
    send_request(CMD_RESERVED, 32'hFFFF_FFFF);
    send_request(CMD_RESERVED, 32'h0000_0005);
    send_request(CMD_ERASE,    32'h8000_0000);
    send_request(CMD_LOOKUP,   32'hFFFF_FFFF);
    send_request(CMD_ERASE,    32'h7FFF_FFFF);
    send_request(CMD_ERASE,    32'h8000_0000);
    send_request(CMD_INSERT,   32'h8000_0000);
    send_request(CMD_ERASE,    32'h8000_0000);
    wait_for_drain();

    // random rounds: fill to overflow, drain, small churn, mixed
    for (int k = 0; k < ROUNDS; k++) begin
      case (k % 4)
        0: begin window = POOL_SIZE; ins_pct = 75; end
        1: begin window = POOL_SIZE; ins_pct = 15; end
        2: begin window = 6;         ins_pct = 40; end
        default: begin window = 40;  ins_pct = 55; end
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 5)
          send_request(2'($urandom_range(0, 3)), $urandom);
        else
          send_request(pick_command(ins_pct), value_pool[$urandom_range(0, window - 1)]);
      end
      if (k == 0 || $urandom_range(0, 2) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: unique_value_set_table.f
design/uvst_pkg.sv
design/uvst_ram.sv
design/uvst_front.sv
design/uvst_back.sv
design/unique_value_set_table.sv
bench/set_table_checker.sv
bench/unique_value_set_table_test.sv
